>>> rtl/core/mpsk_pkg.sv
`default_nettype none
package mpsk_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int ALPHA_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam int ALPHA_W = 16;
  localparam int M2_W    = 48;
  localparam int M4_W    = 64;
  localparam int SNR_W   = 16;
  localparam int LOG_W   = 22;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd66;
  localparam logic [29:0] DB_PER_OCTAVE_Q28  = 30'd808071242;

  typedef struct packed {
    logic [M2_W-1:0] m2;
    logic [M4_W-1:0] m4;
  } moments_t;

  typedef struct packed {
    logic     push;
    moments_t data;
  } push_t;

  typedef struct packed {
    logic     pop;
  } pop_t;

  typedef struct packed {
    logic     full;
    logic     empty;
    moments_t head;
  } queue_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_POW,
    F_SQR,
    F_EMA
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_CMP,
    B_SQRT,
    B_CHK,
    B_NORM,
    B_LOG,
    B_SCALE,
    B_DONE
  } back_state_e;

endpackage
`default_nettype wire

>>> rtl/core/mpsk_snr_estimator_m2m4_unit.sv
// flow: the front captures a sample, forms its power, squares it and updates averages
// the back stops after the compare for a negative radicand, else runs the 49-step
// square root and, when a log is taken, normalize shifts ahead of each 16-step log2
// throughput: one request per back pass, held up by any output stall; the front
// takes no new request while busy; a 2-entry queue lets it run ahead of the back
// reset: asynchronous, active low; averages clear to zero, alpha to 66, no queued requests
`default_nettype none
module mpsk_snr_estimator_m2m4_unit #(
  parameter int SAMPLE_BITS     = mpsk_pkg::SAMPLE_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = mpsk_pkg::ALPHA_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH     = mpsk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [15:0]                   sample_i,
  input  wire logic [15:0]                   sample_q_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [15:0]                 snr_db_o,
  output logic                               estimate_valid_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpsk_pkg::ALPHA_W-1:0]  cfg_wdata_i
);

  mpsk_pkg::push_t         push;
  mpsk_pkg::pop_t          pop;
  mpsk_pkg::queue_status_t status;

  mpsk_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .sample_q_i  (sample_q_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (status.full),
    .push_o      (push)
  );

  mpsk_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (status)
  );

  mpsk_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .status_i         (status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .snr_db_o         (snr_db_o),
    .estimate_valid_o (estimate_valid_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/mpsk_front.sv
`default_nettype none
module mpsk_front #(
  parameter int SAMPLE_BITS     = mpsk_pkg::SAMPLE_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = mpsk_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [15:0]                   sample_i,
  input  wire logic [15:0]                   sample_q_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpsk_pkg::ALPHA_W-1:0]  cfg_wdata_i,
  input  wire logic                          full_i,
  output mpsk_pkg::push_t                    push_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AF   = ALPHA_FRAC_BITS;
  localparam int PW   = 2 * SB;
  localparam int AW   = AF + 1;
  localparam int CMPW = AF + 17;
  localparam int T2W  = mpsk_pkg::M2_W + AF + 2;
  localparam int T4W  = mpsk_pkg::M4_W + AF + 2;
  localparam logic [AW-1:0] ONE = {1'b1, {AF{1'b0}}};

  mpsk_pkg::front_state_e state_q, state_d;
  logic signed [SB-1:0] si_q, si_d, sq_q, sq_d;
  logic [PW-1:0] p_q, p_d;
  logic [mpsk_pkg::M4_W-1:0] pp_q, pp_d;
  logic [mpsk_pkg::M2_W-1:0] m2_q, m2_d;
  logic [mpsk_pkg::M4_W-1:0] m4_q, m4_d;
  logic [mpsk_pkg::ALPHA_W-1:0] alpha_q, alpha_d;

  logic signed [PW-1:0] ii, qq;
  logic [AW-1:0] a, oma;
  logic [mpsk_pkg::M2_W-1:0] v2;
  logic [T2W-1:0] t2;
  logic [T4W-1:0] t4;
  logic push;

  assign ii  = si_q * si_q;
  assign qq  = sq_q * sq_q;
  assign a   = (CMPW'(alpha_q) > CMPW'(ONE)) ? ONE : AW'(alpha_q);
  assign oma = ONE - a;
  assign v2  = mpsk_pkg::M2_W'(p_q) << 16;
  assign t2  = T2W'(a) * T2W'(v2) + T2W'(oma) * T2W'(m2_q) + (T2W'(1) << (AF - 1));
  assign t4  = T4W'(a) * T4W'(pp_q) + T4W'(oma) * T4W'(m4_q) + (T4W'(1) << (AF - 1));
  assign push = (state_q == mpsk_pkg::F_EMA) && !full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpsk_pkg::F_IDLE: if (in_valid_i) state_d = mpsk_pkg::F_POW;
      mpsk_pkg::F_POW:  state_d = mpsk_pkg::F_SQR;
      mpsk_pkg::F_SQR:  state_d = mpsk_pkg::F_EMA;
      mpsk_pkg::F_EMA:  if (!full_i) state_d = mpsk_pkg::F_IDLE;
      default:          state_d = mpsk_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != mpsk_pkg::F_IDLE);
    si_d    = si_q;
    sq_d    = sq_q;
    p_d     = p_q;
    pp_d    = pp_q;
    m2_d    = m2_q;
    m4_d    = m4_q;
    alpha_d = cfg_we_i ? cfg_wdata_i : alpha_q;
    if (state_q == mpsk_pkg::F_IDLE && in_valid_i) begin
      si_d = sample_i[SB-1:0];
      sq_d = sample_q_i[SB-1:0];
    end
    if (state_q == mpsk_pkg::F_POW) p_d = PW'(unsigned'(ii)) + PW'(unsigned'(qq));
    if (state_q == mpsk_pkg::F_SQR) pp_d = mpsk_pkg::M4_W'(p_q * p_q);
    if (push) begin
      m2_d = t2[AF +: mpsk_pkg::M2_W];
      m4_d = t4[AF +: mpsk_pkg::M4_W];
    end
    push_o.push    = push;
    push_o.data.m2 = t2[AF +: mpsk_pkg::M2_W];
    push_o.data.m4 = t4[AF +: mpsk_pkg::M4_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpsk_pkg::F_IDLE;
      m2_q    <= '0;
      m4_q    <= '0;
      alpha_q <= mpsk_pkg::ALPHA_RESET;
    end else begin
      state_q <= state_d;
      m2_q    <= m2_d;
      m4_q    <= m4_d;
      alpha_q <= alpha_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    sq_q <= sq_d;
    p_q  <= p_d;
    pp_q <= pp_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/mpsk_queue.sv
`default_nettype none
module mpsk_queue #(
  parameter int QUEUE_DEPTH = mpsk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mpsk_pkg::push_t     push_i,
  input  wire mpsk_pkg::pop_t      pop_i,
  output mpsk_pkg::queue_status_t  status_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mpsk_pkg::moments_t entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign do_push = push_i.push && (count_q != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop_i.pop && (count_q != '0);

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.head  = entry_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    count_d = count_q;
    if (do_push) wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= push_i.data;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_push_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue push lost");
`endif

endmodule
`default_nettype wire

>>> rtl/core/mpsk_back.sv
`default_nettype none
module mpsk_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mpsk_pkg::queue_status_t      status_i,
  output mpsk_pkg::pop_t                    pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [mpsk_pkg::SNR_W-1:0] snr_db_o,
  output logic                              estimate_valid_o
);

  localparam int M2W = mpsk_pkg::M2_W;
  localparam int LW  = mpsk_pkg::LOG_W;

  mpsk_pkg::back_state_e state_q, state_d;
  logic [M2W-1:0] m2_q, m2_d;
  logic [mpsk_pkg::M4_W-1:0] m4_q, m4_d;
  logic [95:0] acc_q, acc_d;
  logic [97:0] rad_q, rad_d;
  logic [50:0] rem_q, rem_d;
  logic [48:0] root_q, root_d;
  logic [5:0] cnt_q, cnt_d;
  logic [M2W-1:0] x_q, x_d, n_q, n_d;
  logic [5:0] shcnt_q, shcnt_d;
  logic [31:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic phase_q, phase_d;
  logic [LW-1:0] ls_q, ls_d;
  logic neg_q, neg_d;
  logic [22:0] mag_q, mag_d;
  logic ov_q, ov_d;
  logic [15:0] snr_q, snr_d, res_q, res_d;
  logic valid_q, valid_d, rv_q, rv_d;

  logic [23:0] asel, bsel;
  logic [95:0] term;
  logic [96:0] rad2;
  logic [95:0] m4s;
  logic rad_neg;
  logic [52:0] rem_sh, trial;
  logic ge;
  logic [M2W-1:0] s;
  logic [63:0] sqm;
  logic [32:0] sqt;
  logic [LW-1:0] lcur;
  logic signed [23:0] d;
  logic [52:0] prod;
  logic [16:0] q;
  logic load;

  assign asel    = cnt_q[1] ? m2_q[47:24] : m2_q[23:0];
  assign bsel    = cnt_q[0] ? m2_q[47:24] : m2_q[23:0];
  assign term    = (96'(asel * bsel) << (cnt_q[1] ? 24 : 0)) << (cnt_q[0] ? 24 : 0);
  assign rad2    = {acc_q, 1'b0};
  assign m4s     = {m4_q, 32'b0};
  assign rad_neg = rad2 < 97'(m4s);
  assign rem_sh  = {rem_q, rad_q[97:96]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign s       = root_q[48] ? '1 : root_q[47:0];
  assign sqm     = 64'(m_q) * 64'(m_q);
  assign sqt     = sqm[63:31];
  assign lcur    = {6'(6'd47 - shcnt_q), frac_q[14:0], sqt[32]};
  assign d       = $signed({2'b00, ls_q}) - $signed({2'b00, lcur}) + 24'sd65536;
  assign prod    = 53'(mag_q) * 53'(mpsk_pkg::DB_PER_OCTAVE_Q28) + (53'(1) << 35);
  assign q       = prod[52:36];
  assign load    = (state_q == mpsk_pkg::B_DONE) && (!ov_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpsk_pkg::B_IDLE:  if (!status_i.empty) state_d = mpsk_pkg::B_SQ;
      mpsk_pkg::B_SQ:    if (cnt_q[1:0] == 2'd3) state_d = mpsk_pkg::B_CMP;
      mpsk_pkg::B_CMP:   state_d = rad_neg ? mpsk_pkg::B_DONE : mpsk_pkg::B_SQRT;
      mpsk_pkg::B_SQRT:  if (cnt_q == 6'd48) state_d = mpsk_pkg::B_CHK;
      mpsk_pkg::B_CHK:   state_d = (m2_q > s && s != '0) ? mpsk_pkg::B_NORM
                                                         : mpsk_pkg::B_DONE;
      mpsk_pkg::B_NORM:  if (x_q[M2W-1]) state_d = mpsk_pkg::B_LOG;
      mpsk_pkg::B_LOG:   if (cnt_q == 6'd15) state_d = phase_q ? mpsk_pkg::B_SCALE
                                                               : mpsk_pkg::B_NORM;
      mpsk_pkg::B_SCALE: state_d = mpsk_pkg::B_DONE;
      mpsk_pkg::B_DONE:  if (load) state_d = mpsk_pkg::B_IDLE;
      default:           state_d = mpsk_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    m2_d = m2_q;  m4_d = m4_q;  acc_d = acc_q;  rad_d = rad_q;
    rem_d = rem_q;  root_d = root_q;  cnt_d = cnt_q;  x_d = x_q;
    n_d = n_q;  shcnt_d = shcnt_q;  m_d = m_q;  frac_d = frac_q;
    phase_d = phase_q;  ls_d = ls_q;  neg_d = neg_q;  mag_d = mag_q;
    res_d = res_q;  rv_d = rv_q;
    pop_o.pop = 1'b0;
    unique case (state_q)
      mpsk_pkg::B_IDLE: begin
        pop_o.pop = !status_i.empty;
        m2_d  = status_i.head.m2;
        m4_d  = status_i.head.m4;
        acc_d = '0;
        cnt_d = '0;
      end
      mpsk_pkg::B_SQ: begin
        acc_d = acc_q + term;
        cnt_d = cnt_q + 1'b1;
      end
      mpsk_pkg::B_CMP: begin
        rad_d  = {1'b0, rad2 - 97'(m4s)};
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
        res_d  = '0;
        rv_d   = 1'b0;
      end
      mpsk_pkg::B_SQRT: begin
        rem_d  = ge ? 51'(rem_sh - trial) : 51'(rem_sh);
        root_d = {root_q[47:0], ge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + 1'b1;
      end
      mpsk_pkg::B_CHK: begin
        n_d     = m2_q - s;
        x_d     = s;
        shcnt_d = '0;
        phase_d = 1'b0;
        if (m2_q > s) begin
          rv_d = 1'b1;
          if (s == '0) res_d = 16'h8000;
        end
      end
      mpsk_pkg::B_NORM: begin
        if (x_q[M2W-1]) begin
          m_d    = x_q[M2W-1 -: 32];
          frac_d = '0;
          cnt_d  = '0;
        end else begin
          x_d     = x_q << 1;
          shcnt_d = shcnt_q + 1'b1;
        end
      end
      mpsk_pkg::B_LOG: begin
        m_d    = sqt[32] ? sqt[32:1] : sqt[31:0];
        frac_d = {frac_q[14:0], sqt[32]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 6'd15) begin
          if (!phase_q) begin
            ls_d    = lcur;
            x_d     = n_q;
            shcnt_d = '0;
            phase_d = 1'b1;
          end else begin
            neg_d = d[23];
            mag_d = d[23] ? 23'(-d) : 23'(d);
          end
        end
      end
      mpsk_pkg::B_SCALE: begin
        if (neg_q) res_d = 16'(17'h10000 - ((q > 17'd32768) ? 17'd32768 : q));
        else       res_d = (q > 17'd32767) ? 16'h7fff : q[15:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_d    = load ? 1'b1 : (ov_q && out_stall_i);
    snr_d   = load ? res_q : snr_q;
    valid_d = load ? rv_q : valid_q;
    out_valid_o      = ov_q;
    snr_db_o         = snr_q;
    estimate_valid_o = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpsk_pkg::B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q <= m2_d;  m4_q <= m4_d;  acc_q <= acc_d;  rad_q <= rad_d;
    rem_q <= rem_d;  root_q <= root_d;  cnt_q <= cnt_d;  x_q <= x_d;
    n_q <= n_d;  shcnt_q <= shcnt_d;  m_q <= m_d;  frac_q <= frac_d;
    phase_q <= phase_d;  ls_q <= ls_d;  neg_q <= neg_d;  mag_q <= mag_d;
    res_q <= res_d;  rv_q <= rv_d;  snr_q <= snr_d;  valid_q <= valid_d;
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !valid_q) |-> (snr_q == '0)) else $error("invalid estimate not zero");
  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpsk_pkg::B_LOG) |-> m_q[31]) else $error("log mantissa not normalized");
  a_sqrt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpsk_pkg::B_SQRT) |-> (cnt_q <= 6'd48)) else $error("root count overrun");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o.pop |=> (state_q == mpsk_pkg::B_SQ)) else $error("pop outside fetch");
`endif

endmodule
`default_nettype wire

>>> sim/mpsk_snr_checker.sv
`default_nettype none
module mpsk_snr_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [15:0] sample_i,
  input  wire logic [15:0] sample_q_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [15:0] snr_db_i,
  input  wire logic        estimate_valid_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct {
    logic [15:0] snr;
    logic        ok;
  } estimate_t;

  estimate_t   est_q[$];
  logic [15:0] alpha;
  logic [47:0] m2_avg;
  logic [63:0] m4_avg;

  function automatic logic [63:0] smooth(logic [63:0] prev, logic [63:0] value,
                                         logic [15:0] a);
    logic [127:0] t;
    t = 128'(a) * 128'(value) + 128'(17'h10000 - 17'(a)) * 128'(prev) + 128'h8000;
    return t[79:16];
  endfunction

  function automatic int log2_q16(logic [63:0] x);
    int          msb;
    logic [63:0] m;
    int          frac;
    msb = 0;
    frac = 0;
    while (msb < 62 && (x >> (msb + 1)) != 0) msb++;
    if (msb <= 31) m = x << (31 - msb);
    else m = x >> (msb - 31);
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        frac |= 1 << k;
        m >>= 1;
      end
    end
    return msb * 65536 + frac;
  endfunction

  function automatic estimate_t estimate(logic [15:0] si_raw, logic [15:0] sq_raw);
    estimate_t    r;
    longint       si, sq;
    logic [63:0]  pw, sroot, c, noise, mag, qv;
    logic [127:0] rad, m4w;
    longint       d;
    si = longint'($signed(si_raw));
    sq = longint'($signed(sq_raw));
    pw = 64'(si * si + sq * sq);
    m2_avg = 48'(smooth(64'(m2_avg), pw << 16, alpha));
    m4_avg = smooth(m4_avg, pw * pw, alpha);
    r.snr = '0;
    r.ok = 1'b0;
    rad = 128'(m2_avg) * 128'(m2_avg);
    rad = rad << 1;
    m4w = 128'(m4_avg) << 32;
    if (rad >= m4w) begin
      rad = rad - m4w;
      sroot = '0;
      for (int b = 47; b >= 0; b--) begin
        c = sroot | (64'd1 << b);
        if (rad >= 128'(c) * 128'(c)) sroot = c;
      end
      if (64'(m2_avg) > sroot) begin
        noise = 64'(m2_avg) - sroot;
        r.ok = 1'b1;
        if (sroot == 0) begin
          r.snr = 16'h8000;
        end else begin
          d = longint'(log2_q16(sroot)) - longint'(log2_q16(noise)) + 65536;
          mag = (d < 0) ? 64'(-d) : 64'(d);
          qv = (mag * 64'd808071242 + (64'd1 << 35)) >> 36;
          if (d < 0) begin
            if (qv > 32768) qv = 32768;
            r.snr = 16'(17'h10000 - 17'(qv));
          end else begin
            if (qv > 32767) qv = 32767;
            r.snr = qv[15:0];
          end
        end
      end
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    estimate_t e;
    if (!rst_ni) begin
      alpha = mpsk_pkg::ALPHA_RESET;
      m2_avg = '0;
      m4_avg = '0;
      est_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) alpha = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) est_q.push_back(estimate(sample_i, sample_q_i));
      if (out_valid_i && !out_stall_i) begin
        if (est_q.size() == 0) begin
          $display("%0t: unexpected result snr=%0d valid=%0b", $time,
                   $signed(snr_db_i), estimate_valid_i);
          errors_o++;
        end else begin
          e = est_q.pop_front();
          if (e.snr !== snr_db_i) begin
            $display("%0t: snr_db expected %0d actual %0d", $time, $signed(e.snr),
                     $signed(snr_db_i));
            errors_o++;
          end
          if (e.ok !== estimate_valid_i) begin
            $display("%0t: estimate_valid expected %0b actual %0b", $time, e.ok,
                     estimate_valid_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = est_q.size();
  end

endmodule
`default_nettype wire

>>> sim/tb_mpsk_snr_estimator_m2m4_unit.sv
`default_nettype none
module tb_mpsk_snr_estimator_m2m4_unit;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] samp_i = '0;
  logic [15:0] samp_q = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] snr_db;
  logic        est_valid;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          errors;
  int          pending;
  bit          quiet = 1'b0;
  int          cycles = 0;

  mpsk_snr_estimator_m2m4_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_i        (samp_i),
    .sample_q_i      (samp_q),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .snr_db_o        (snr_db),
    .estimate_valid_o(est_valid),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  mpsk_snr_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sample_i        (samp_i),
    .sample_q_i      (samp_q),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .snr_db_i        (snr_db),
    .estimate_valid_i(est_valid),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(logic [15:0] i_val, logic [15:0] q_val);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    samp_i <= i_val;
    samp_q <= q_val;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain_and_set_alpha(logic [15:0] a);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic psk_burst(int n, int amp, int noise);
    int s_i, s_q;
    for (int k = 0; k < n; k++) begin
      s_i = ($urandom_range(0, 1) ? amp : -amp) + $urandom_range(0, 2 * noise) - noise;
      s_q = ($urandom_range(0, 1) ? amp : -amp) + $urandom_range(0, 2 * noise) - noise;
      if (s_i > 32767) s_i = 32767;
      if (s_i < -32768) s_i = -32768;
      if (s_q > 32767) s_q = 32767;
      if (s_q < -32768) s_q = -32768;
      send_sample(16'(s_i), 16'(s_q));
    end
  endtask

  task automatic noise_burst(int n);
    for (int k = 0; k < n; k++) send_sample(16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset alpha, extremes, zero power
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0001, 16'hffff);
    drain_and_set_alpha(16'hffff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0100, 16'h0000);
    send_sample(16'h0000, 16'h0100);
    drain_and_set_alpha(16'h8000);
    send_sample(16'h1000, 16'h1000);
    send_sample(16'hf000, 16'h1000);
    send_sample(16'h1000, 16'hf000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    drain_and_set_alpha(16'h0001);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h0000);
    drain_and_set_alpha(16'h4000);

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 12) quiet = 1'b1;
      psk_burst(70, $urandom_range(1, 30000), $urandom_range(0, 3000));
      noise_burst(15);
      psk_burst(15, $urandom_range(1, 200), $urandom_range(0, 50));
      case (ph % 4)
        0: drain_and_set_alpha(16'hffff);
        1: drain_and_set_alpha(16'h0001);
        2: drain_and_set_alpha(16'($urandom_range(1, 65535)));
        default: drain_and_set_alpha(16'($urandom_range(2000, 40000)));
      endcase
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/mpsk_pkg.sv
rtl/core/mpsk_front.sv
rtl/core/mpsk_queue.sv
rtl/core/mpsk_back.sv
rtl/core/mpsk_snr_estimator_m2m4_unit.sv
sim/mpsk_snr_checker.sv
sim/tb_mpsk_snr_estimator_m2m4_unit.sv
